### hdl/accel_window_stddev_activity_unit_assert.svh
// assertion macros for the activity unit
`ifndef ACCEL_WINDOW_STDDEV_ACTIVITY_UNIT_ASSERT_SVH
`define ACCEL_WINDOW_STDDEV_ACTIVITY_UNIT_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define AWS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define AWS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### hdl/aws_pkg.sv
// ----------------------------------------------------------------------------
// aws_pkg
// shared constants for the window standard deviation activity unit
// ----------------------------------------------------------------------------
`default_nettype none
package aws_pkg;
  localparam int unsigned Window   = 100;
  localparam int unsigned IdxW     = $clog2(Window);
  localparam int unsigned CntW     = $clog2(Window + 1);
  localparam int unsigned SumW     = 16 + CntW;
  localparam int unsigned SqW      = 32 + CntW;
  localparam int unsigned NqW      = SqW + CntW;
  localparam int unsigned RootW    = NqW / 2 + 1;
  localparam logic [13:0] ScoreMax = 14'h3fff;

  typedef enum logic [1:0] {
    CFG_MIN_SAMPLES = 2'd0,
    CFG_LOW_THR     = 2'd1,
    CFG_HIGH_THR    = 2'd2
  } cfg_idx_e;
endpackage
`default_nettype wire

### hdl/aws_ram.sv
// ----------------------------------------------------------------------------
// aws_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module aws_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 100
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

### hdl/accel_window_stddev_activity_unit.sv
// a sample transaction keeps the unit busy through its squaring, root and
// ram update steps; a report through its multiply, root, divide and score
// steps, the divide skipped for an empty window, until its result is taken;
// one at a time, set by the bit-serial multiply, square root and divide loops
// reset: asynchronous active low; window empty, thresholds 10 / 573 / 5243;
// the magnitude ram needs no clearing, entries are read only after a wrap
// ----------------------------------------------------------------------------
// accel_window_stddev_activity_unit
// windowed standard deviation of acceleration magnitude with band score
// ----------------------------------------------------------------------------
`default_nettype none
`include "accel_window_stddev_activity_unit_assert.svh"
module accel_window_stddev_activity_unit
  import aws_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        kind_i,
  input  wire logic [15:0] accel_x_i,
  input  wire logic [15:0] accel_y_i,
  input  wire logic [15:0] accel_z_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [13:0]      activity_score_o,
  output logic [14:0]      deviation_counts_o,
  output logic [6:0]       window_count_o,
  output logic             in_band_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_MROOT, ST_RAM, ST_OLDSQ, ST_UPD,
    ST_NQ, ST_SS, ST_DROOT, ST_DIV, ST_SCORE, ST_OUT
  } state_e;

  localparam int unsigned MulW = NqW;
  localparam int unsigned MCntW = $clog2(MulW + 1);

  state_e            state_q;
  logic [6:0]        min_q;
  logic [15:0]       low_q, high_q;
  logic [IdxW-1:0]   widx_q;
  logic              full_q;
  logic [SumW-1:0]   sum_q;
  logic [SqW-1:0]    sq_q;
  logic [1:0]        axis_q;
  logic [15:0]       ax_q [3];
  // shift-add multiplier: multiplicand a, multiplier b (lsb first), product p
  logic [MulW-1:0]   ma_q, mb_q, mp_q;
  logic [MCntW-1:0]  cnt_q;
  logic [MulW-1:0]   acc_q;
  // restoring root / divide
  logic [MulW-1:0]   rem_q;
  logic [RootW-1:0]  root_q;
  logic [RootW-1:0]  quo_q;
  logic [15:0]       mag_q;
  logic [15:0]       old_q;
  logic [MulW-1:0]   nq_q;
  logic [14:0]       sd_q;
  logic              ram_we;
  logic [15:0]       ram_rd;
  logic [CntW-1:0]   n_w;
  logic [MulW+1:0]   trial;
  logic [MulW-1:0]   rem_sh;
  logic [RootW:0]    dsh;
  logic [RootW:0]    dn;
  logic [19:0]       sc_w;
  logic              band_w;
  logic [1:0]        nxt_axis;
  logic [15:0]       abs_x;
  logic [15:0]       abs_nxt;

  assign n_w = full_q ? CntW'(Window) : CntW'(widx_q);
  assign in_ready_o = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign nxt_axis = axis_q + 2'd1;
  assign abs_x = accel_x_i[15] ? -accel_x_i : accel_x_i;
  assign abs_nxt = ax_q[nxt_axis][15] ? -ax_q[nxt_axis] : ax_q[nxt_axis];

  aws_ram #(.Width(16), .Depth(Window)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (widx_q),
    .wdata_i(mag_q),
    .rdata_o(ram_rd)
  );
  assign ram_we = (state_q == ST_UPD) && (cnt_q == '0);

  // one root digit: shift two bits of the radicand in, try 4r+1
  assign rem_sh = {rem_q[MulW-3:0], acc_q[MulW-1 -: 2]};
  assign trial = {2'b00, rem_sh} - {{(MulW-RootW){1'b0}}, root_q, 2'b01};
  // one divide step on the root value by n, root bits enter msb first
  assign dsh = {rem_q[RootW-1:0], acc_q[RootW-1]};
  assign dn = {{(RootW+1-CntW){1'b0}}, n_w};
  assign sc_w = ({5'b0, sd_q} * 20'd25) >> 4;
  assign band_w = ({1'b0, n_w} >= (CntW+1)'(min_q)) &&
                  ({1'b0, sd_q} >= low_q) && ({1'b0, sd_q} <= high_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      min_q <= 7'd10;
      low_q <= 16'd573;
      high_q <= 16'd5243;
      widx_q <= '0;
      full_q <= 1'b0;
      sum_q <= '0;
      sq_q <= '0;
      out_valid_o <= 1'b0;
      cnt_q <= '0;
      axis_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_MIN_SAMPLES: min_q <= cfg_data_i[6:0];
          CFG_LOW_THR:     low_q <= cfg_data_i;
          CFG_HIGH_THR:    high_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (!kind_i) begin
              ax_q[0] <= accel_x_i;
              ax_q[1] <= accel_y_i;
              ax_q[2] <= accel_z_i;
              axis_q <= '0;
              acc_q <= '0;
              ma_q <= MulW'(abs_x);
              mb_q <= MulW'(abs_x);
              mp_q <= '0;
              cnt_q <= MCntW'(17);
              state_q <= ST_SQ;
            end else begin
              ma_q <= MulW'(sq_q);
              mb_q <= MulW'(n_w);
              mp_q <= '0;
              cnt_q <= MCntW'(CntW);
              state_q <= ST_NQ;
            end
          end
        end
        ST_SQ: begin
          if (cnt_q != '0) begin
            if (mb_q[0]) mp_q <= mp_q + ma_q;
            ma_q <= ma_q << 1;
            mb_q <= mb_q >> 1;
            cnt_q <= cnt_q - 1'b1;
          end else if (axis_q != 2'd2) begin
            acc_q <= acc_q + mp_q;
            axis_q <= nxt_axis;
            ma_q <= MulW'(abs_nxt);
            mb_q <= MulW'(abs_nxt);
            mp_q <= '0;
            cnt_q <= MCntW'(17);
          end else begin
            acc_q <= (acc_q + mp_q) << (MulW - 34);
            rem_q <= '0;
            root_q <= '0;
            cnt_q <= MCntW'(17);
            state_q <= ST_MROOT;
          end
        end
        ST_MROOT, ST_DROOT: begin
          if (cnt_q != '0) begin
            acc_q <= acc_q << 2;
            if (!trial[MulW+1]) begin
              rem_q <= trial[MulW-1:0];
              root_q <= {root_q[RootW-2:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              root_q <= {root_q[RootW-2:0], 1'b0};
            end
            cnt_q <= cnt_q - 1'b1;
          end else if (state_q == ST_MROOT) begin
            mag_q <= root_q[15:0];
            cnt_q <= MCntW'(1);
            state_q <= ST_RAM;
          end else begin
            acc_q <= MulW'(root_q);
            rem_q <= '0;
            quo_q <= '0;
            cnt_q <= MCntW'(RootW);
            state_q <= ST_DIV;
          end
        end
        ST_RAM: begin
          // wait for the registered read of the entry about to be replaced
          if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
          else begin
            old_q <= full_q ? ram_rd : 16'd0;
            ma_q <= MulW'(full_q ? ram_rd : 16'd0);
            mb_q <= MulW'(full_q ? ram_rd : 16'd0);
            mp_q <= '0;
            cnt_q <= MCntW'(16);
            state_q <= ST_OLDSQ;
          end
        end
        ST_OLDSQ: begin
          if (cnt_q != '0) begin
            if (mb_q[0]) mp_q <= mp_q + ma_q;
            ma_q <= ma_q << 1;
            mb_q <= mb_q >> 1;
            cnt_q <= cnt_q - 1'b1;
          end else begin
            sq_q <= sq_q - SqW'(mp_q);
            sum_q <= sum_q - SumW'(old_q);
            ma_q <= MulW'(mag_q);
            mb_q <= MulW'(mag_q);
            mp_q <= '0;
            cnt_q <= MCntW'(16);
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (cnt_q != '0) begin
            if (mb_q[0]) mp_q <= mp_q + ma_q;
            ma_q <= ma_q << 1;
            mb_q <= mb_q >> 1;
            cnt_q <= cnt_q - 1'b1;
          end else begin
            sq_q <= sq_q + SqW'(mp_q);
            sum_q <= sum_q + SumW'(mag_q);
            if (widx_q == IdxW'(Window - 1)) begin
              widx_q <= '0;
              full_q <= 1'b1;
            end else begin
              widx_q <= widx_q + 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_NQ: begin
          if (cnt_q != '0) begin
            if (mb_q[0]) mp_q <= mp_q + ma_q;
            ma_q <= ma_q << 1;
            mb_q <= mb_q >> 1;
            cnt_q <= cnt_q - 1'b1;
          end else begin
            nq_q <= mp_q;
            ma_q <= MulW'(sum_q);
            mb_q <= MulW'(sum_q);
            mp_q <= '0;
            cnt_q <= MCntW'(SumW);
            state_q <= ST_SS;
          end
        end
        ST_SS: begin
          if (cnt_q != '0) begin
            if (mb_q[0]) mp_q <= mp_q + ma_q;
            ma_q <= ma_q << 1;
            mb_q <= mb_q >> 1;
            cnt_q <= cnt_q - 1'b1;
          end else begin
            acc_q <= (nq_q > mp_q) ? nq_q - mp_q : '0;
            rem_q <= '0;
            root_q <= '0;
            cnt_q <= MCntW'(MulW / 2);
            state_q <= ST_DROOT;
          end
        end
        ST_DIV: begin
          if (n_w == '0) begin
            sd_q <= '0;
            state_q <= ST_SCORE;
          end else if (cnt_q != '0) begin
            acc_q <= acc_q << 1;
            if (dsh >= dn) begin
              rem_q <= MulW'(dsh - dn);
              quo_q <= {quo_q[RootW-2:0], 1'b1};
            end else begin
              rem_q <= MulW'(dsh);
              quo_q <= {quo_q[RootW-2:0], 1'b0};
            end
            cnt_q <= cnt_q - 1'b1;
          end else begin
            sd_q <= quo_q[14:0];
            state_q <= ST_SCORE;
          end
        end
        ST_SCORE: begin
          in_band_o <= band_w;
          deviation_counts_o <= sd_q;
          window_count_o <= 7'(n_w);
          activity_score_o <= !band_w ? '0 :
                              (sc_w > 20'(ScoreMax)) ? ScoreMax : sc_w[13:0];
          out_valid_o <= 1'b1;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_valid_o && out_ready_i) begin
            out_valid_o <= 1'b0;
            widx_q <= '0;
            full_q <= 1'b0;
            sum_q <= '0;
            sq_q <= '0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `AWS_ASSERT_IMP(a_ready_idle, in_ready_o, !out_valid_o)
  `AWS_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(deviation_counts_o))
  `AWS_ASSERT_IMP(a_score_band, out_valid_o && !in_band_o, activity_score_o == '0)
endmodule
`default_nettype wire

### tb/tb_accel_window_stddev_activity_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_window_stddev_activity_unit
// drives accelerometer samples and report requests through the activity unit
// and checks each report against a bit-accurate window statistics predictor
// ----------------------------------------------------------------------------
module tb_accel_window_stddev_activity_unit
  import aws_pkg::*;
();

  localparam int unsigned WinDepth  = Window;
  localparam longint      CycleLimit = 2_000_000;

  typedef struct packed {
    logic [13:0] score;
    logic [14:0] deviation;
    logic [6:0]  count;
    logic        band;
  } report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        kind_i = 1'b0;
  logic [15:0] accel_x_i = '0;
  logic [15:0] accel_y_i = '0;
  logic [15:0] accel_z_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [13:0] activity_score_o;
  logic [14:0] deviation_counts_o;
  logic [6:0]  window_count_o;
  logic        in_band_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  accel_window_stddev_activity_unit dut (.*);

  // predictor state
  logic [15:0] mag_ring [WinDepth];
  int unsigned ring_wr;
  bit          ring_full;
  longint unsigned mag_sum, mag_sq_sum;
  logic [6:0]  min_samples_q = 7'd10;
  logic [15:0] low_thr_q = 16'd573;
  logic [15:0] high_thr_q = 16'd5243;

  report_t expected_reports[$];
  int      error_count = 0;
  longint  cycle_count = 0;
  int      reports_seen = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic void clear_window();
    ring_wr = 0;
    ring_full = 0;
    mag_sum = 0;
    mag_sq_sum = 0;
  endfunction

  task automatic predict_window(input logic kind, input logic [15:0] ax, ay, az);
    longint signed x, y, z;
    longint unsigned m, n, nq, ss, d, sd, score;
    report_t r;
    bit band;
    if (!kind) begin
      x = $signed(ax);
      y = $signed(ay);
      z = $signed(az);
      m = isqrt(x * x + y * y + z * z);
      if (ring_full) begin
        mag_sum -= mag_ring[ring_wr];
        mag_sq_sum -= longint'(mag_ring[ring_wr]) * mag_ring[ring_wr];
      end
      mag_ring[ring_wr] = m[15:0];
      mag_sum += m;
      mag_sq_sum += m * m;
      ring_wr++;
      if (ring_wr >= WinDepth) begin
        ring_wr = 0;
        ring_full = 1;
      end
    end else begin
      n = ring_full ? WinDepth : ring_wr;
      sd = 0;
      score = 0;
      if (n != 0) begin
        nq = n * mag_sq_sum;
        ss = mag_sum * mag_sum;
        d = (nq > ss) ? nq - ss : 0;
        sd = isqrt(d) / n;
      end
      band = (n >= min_samples_q) && (sd >= low_thr_q) && (sd <= high_thr_q);
      if (band) begin
        score = (sd * 25) >> 4;
        if (score > ScoreMax) score = ScoreMax;
      end
      r.score = score[13:0];
      r.deviation = sd[14:0];
      r.count = n[6:0];
      r.band = band;
      expected_reports.push_back(r);
      clear_window();
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("mismatch on %s: got %0d expected %0d", what, got, want);
  endtask

  // result checker with random stalls
  always @(posedge clk_i) begin
    report_t want;
    if (out_valid_o && out_ready_i) begin
      reports_seen <= reports_seen + 1;
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected report", 1, 0);
      end else begin
        want = expected_reports.pop_front();
        if (activity_score_o !== want.score)
          report_mismatch("activity_score", activity_score_o, want.score);
        if (deviation_counts_o !== want.deviation)
          report_mismatch("deviation_counts", deviation_counts_o, want.deviation);
        if (window_count_o !== want.count)
          report_mismatch("window_count", window_count_o, want.count);
        if (in_band_o !== want.band)
          report_mismatch("in_band", in_band_o, want.band);
      end
    end
    if (rst_ni) begin
      if ($urandom_range(0, 9) < 7) out_ready_i <= 1'b1;
      else if ($urandom_range(0, 19) == 0) out_ready_i <= 1'b0;
      else out_ready_i <= ($urandom_range(0, 3) == 0);
    end
  end

  task automatic idle_gap();
    int g;
    g = $urandom_range(0, 9);
    if (g < 5) g = 1;
    else if (g < 9) g = $urandom_range(1, 4);
    else g = $urandom_range(20, 300);
    repeat (g) @(posedge clk_i);
  endtask

  task automatic send_item(input logic kind, input logic [15:0] ax, ay, az);
    in_valid_i <= 1'b1;
    kind_i <= kind;
    accel_x_i <= ax;
    accel_y_i <= ay;
    accel_z_i <= az;
    do @(posedge clk_i); while (!in_ready_o);
    predict_window(kind, ax, ay, az);
    in_valid_i <= 1'b0;
    idle_gap();
  endtask

  task automatic send_sample(input logic [15:0] ax, ay, az);
    send_item(1'b0, ax, ay, az);
  endtask

  task automatic send_report();
    send_item(1'b1, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MIN_SAMPLES: min_samples_q = value[6:0];
      CFG_LOW_THR:     low_thr_q = value;
      CFG_HIGH_THR:    high_thr_q = value;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [6:0] mins, input logic [15:0] lo, hi);
    drain();
    write_reg(CFG_MIN_SAMPLES, {9'd0, mins});
    write_reg(CFG_LOW_THR, lo);
    write_reg(CFG_HIGH_THR, hi);
  endtask

  // gravity with random jitter, well-formed motion around 1 g
  function automatic logic [15:0] jitter_axis(input int base, input int spread);
    return 16'(base + $signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  task automatic test_extremes();
    send_report();
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h7fff, 16'h7fff);
    send_sample(16'h0000, 16'h0000, 16'h0000);
    send_sample(16'hffff, 16'h0001, 16'h8000);
    send_report();
    repeat (12) send_sample(16'h8000, 16'h0, 16'h0);
    repeat (3) send_sample(16'h0, 16'h0, 16'h0);
    send_report();
    send_report();
  endtask

  task automatic test_empty_window_in_band();
    configure(7'd0, 16'd0, 16'd100);
    send_report();
    send_sample(16'd100, 16'd0, 16'd0);
    send_report();
  endtask

  task automatic test_inverted_thresholds();
    configure(7'd1, 16'd6000, 16'd10);
    repeat (20) send_sample(jitter_axis(0, 9000), jitter_axis(0, 9000), 16'd16384);
    send_report();
  endtask

  task automatic test_large_score();
    configure(7'd2, 16'd0, 16'hffff);
    repeat (10) begin
      send_sample(16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h0, 16'h0, 16'h0);
    end
    send_report();
  endtask

  task automatic test_min_above_window();
    configure(7'd127, 16'd0, 16'hffff);
    repeat (130) send_sample(jitter_axis(0, 3000), jitter_axis(0, 3000), 16'd16384);
    send_report();
  endtask

  task automatic test_random(input int items);
    int sent, burst;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 3) == 0)
        configure(7'($urandom_range(1, 100)), 16'($urandom_range(0, 1500)),
                  16'($urandom_range(1000, 65535)));
      else if ($urandom_range(0, 7) == 0) drain();  // sender waits for all reports
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(90, 220) : $urandom_range(0, 30);
      repeat (burst) begin
        if ($urandom_range(0, 9) == 0)
          send_sample(16'($urandom), 16'($urandom), 16'($urandom));
        else
          send_sample(jitter_axis(0, 4000), jitter_axis(0, 4000),
                      jitter_axis(16384, 4000));
      end
      send_report();
      sent += burst + 1;
    end
  endtask

  initial begin
    clear_window();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_empty_window_in_band();
    test_inverted_thresholds();
    test_large_score();
    test_min_above_window();
    configure(7'd100, 16'd0, 16'd0);
    send_report();
    configure(7'd10, 16'd573, 16'd5243);
    test_random(1350);
    drain();
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
